>>> rtl/mbps_pkg.sv
package mbps_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned IdxW       = $clog2(MaxPattern);
  localparam int unsigned LenW       = 4;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgPatternBytes  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternMask   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAlignMask     = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
  } mbps_link_t;

  typedef struct packed {
    logic [7:0] bits;
    logic [7:0] mask;
    logic       used;
  } mbps_pat_t;

  // Clamp the programmed length to the window depth.
  function automatic logic [LenW-1:0] mbps_len_sat(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = (len > LenW'(MaxPattern)) ? LenW'(MaxPattern) : len;
    return r;
  endfunction

  // Cell k compares the k-th newest byte (k = 0 is the incoming byte); it checks pattern position len-1-k.
  function automatic mbps_pat_t mbps_cell_pat(input logic [CfgW-1:0] bytes,
                                              input logic [CfgW-1:0] mask,
                                              input logic [LenW-1:0] len,
                                              input logic [IdxW-1:0] k);
    mbps_pat_t       p;
    logic [LenW-1:0] pos;
    logic [IdxW-1:0] lane;
    pos    = len - LenW'(1) - LenW'(k);
    lane   = pos[IdxW-1:0];
    p.bits = bytes[8*lane +: 8];
    p.mask = mask[8*lane +: 8];
    p.used = (len != '0) && (LenW'(k) < len);
    return p;
  endfunction

endpackage

>>> rtl/mbps_cell.sv
module mbps_cell import mbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  mbps_link_t link_i,
  input  mbps_pat_t  pat_i,
  output mbps_link_t link_o,
  output logic       match_o
);

  logic [7:0] data_q;
  logic       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= link_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= link_i.data;
    end
  end

  assign link_o.data = data_q;
  assign link_o.vld  = vld_q;

  assign match_o = !pat_i.used ||
                   (link_i.vld && ((link_i.data & pat_i.mask) == pat_i.bits));

endmodule

>>> rtl/masked_byte_pattern_scanner.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-----------------------------------------
// in      | input     | in_valid_i/in_stall_o | data_byte_i, region_start_i, region_base_i
// out     | output    | out_valid_o/out_stall_i | match_address_o
// cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One byte per cycle while in_stall_o is low; a match address appears in the cycle
// after the transfer of the byte that ends it. The window shifts through a row of
// eight byte cells that compare in parallel, so latency is set by the output register
// alone. Reset clears the cell valid bits, the address counter and the output valid.
// in_stall_o rises only while a result is held and out_stall_i is high.
module masked_byte_pattern_scanner import mbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                region_start_i,
  input  logic [AddrW-1:0]    region_base_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [AddrW-1:0]    match_address_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  logic [CfgW-1:0]  pat_bytes_q;
  logic [CfgW-1:0]  pat_mask_q;
  logic [LenW-1:0]  pat_len_q;
  logic [1:0]       align_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_mask_q  <= '0;
      pat_len_q   <= LenW'(1);
      align_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatternBytes:  pat_bytes_q <= cfg_data_i;
        CfgPatternMask:   pat_mask_q  <= cfg_data_i;
        CfgPatternLength: pat_len_q   <= cfg_data_i[LenW-1:0];
        CfgAlignMask:     align_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic             accept;
  logic [LenW-1:0]  len_eff;
  mbps_link_t       link_in  [MaxPattern];
  mbps_link_t       link_out [MaxPattern];
  logic [MaxPattern-1:0] match_vec;
  logic [MaxPattern-1:0] vld_vec;

  assign accept  = in_valid_i && !in_stall_o;
  assign len_eff = mbps_len_sat(pat_len_q);

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign link_in[k].data = data_byte_i;
      assign link_in[k].vld  = 1'b1;
    end else begin : g_body
      assign link_in[k].data = link_out[k-1].data;
      assign link_in[k].vld  = link_out[k-1].vld && !region_start_i;
    end

    mbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .link_i  (link_in[k]),
      .pat_i   (mbps_cell_pat(pat_bytes_q, pat_mask_q, len_eff, IdxW'(k))),
      .link_o  (link_out[k]),
      .match_o (match_vec[k])
    );

    assign vld_vec[k] = link_out[k].vld;
  end

  logic [AddrW-1:0] next_addr_q, next_addr_d;
  logic [AddrW-1:0] cur_addr, first_addr;
  logic             hit;

  assign cur_addr    = region_start_i ? region_base_i : next_addr_q;
  assign next_addr_d = cur_addr + AddrW'(1);
  assign first_addr  = cur_addr - AddrW'(len_eff - LenW'(1));
  assign hit         = (len_eff != '0) && (&match_vec) && ((first_addr[1:0] & align_q) == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_addr_q <= '0;
    end else if (accept) begin
      next_addr_q <= next_addr_d;
    end
  end

  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_addr_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = hit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      out_addr_q <= first_addr;
    end
  end

  assign in_stall_o      = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign match_address_o = out_addr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && region_start_i) |=> (vld_vec == MaxPattern'(1)))
    else $error("region start did not restart the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(vld_vec) && $stable(next_addr_q))
    else $error("window moved without a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result appeared without an input transfer");

endmodule

>>> sim/mbps_checker.sv
`timescale 1ns / 100ps

module mbps_checker import mbps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         data_byte_i,
  input  logic               region_start_i,
  input  logic [AddrW-1:0]   region_base_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [AddrW-1:0]   match_address_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  logic [CfgW-1:0]  pat_bytes;
  logic [CfgW-1:0]  pat_mask;
  logic [LenW-1:0]  pat_len;
  logic [1:0]       align;
  logic [7:0]       window [MaxPattern];
  logic [LenW-1:0]  fill;
  logic [AddrW-1:0] next_addr;
  logic [AddrW-1:0] match_q [$];
  logic [AddrW-1:0] want;
  int unsigned      err_cnt = 0;

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] exp_addr);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, exp_addr);
    err_cnt++;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic start,
                           input logic [AddrW-1:0] base);
    logic [AddrW-1:0] cur;
    logic [AddrW-1:0] first;
    int unsigned      n;
    bit               hit;
    if (start) begin
      fill      = '0;
      next_addr = base;
    end
    for (int i = MaxPattern - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    cur       = next_addr;
    next_addr = next_addr + 1;
    if (fill < LenW'(MaxPattern)) fill++;
    n = (pat_len > LenW'(MaxPattern)) ? MaxPattern : pat_len;
    if (n == 0 || fill < n) return;
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ((window[n-1-i] & pat_mask[8*i +: 8]) != pat_bytes[8*i +: 8]) hit = 1'b0;
    end
    first = cur - AddrW'(n - 1);
    if (hit && (first[1:0] & align) == 2'b00) match_q.push_back(first);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes = '0;
      pat_mask  = '0;
      pat_len   = LenW'(1);
      align     = '0;
      foreach (window[i]) window[i] = '0;
      fill      = '0;
      next_addr = '0;
      match_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) scan_byte(data_byte_i, region_start_i, region_base_i);
      if (out_valid_i && !out_stall_i) begin
        if (match_q.size() == 0) begin
          report_mismatch("unexpected match_address", match_address_i, '0);
        end else begin
          want = match_q.pop_front();
          if (match_address_i !== want) report_mismatch("match_address", match_address_i, want);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPatternBytes:  pat_bytes = cfg_data_i;
          CfgPatternMask:   pat_mask  = cfg_data_i;
          CfgPatternLength: pat_len   = cfg_data_i[LenW-1:0];
          CfgAlignMask:     align     = cfg_data_i[1:0];
          default: ;
        endcase
      end
      errors_o  <= err_cnt;
      pending_o <= match_q.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import mbps_pkg::*;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainLimit  = 5000;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte    = '0;
  logic               region_start = 1'b0;
  logic [AddrW-1:0]   region_base  = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [AddrW-1:0]   match_address;
  logic               cfg_we       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx      = CfgPatternBytes;
  logic [CfgW-1:0]    cfg_data     = '0;
  int unsigned        errors;
  int unsigned        pending;

  logic               hold_req     = 1'b0;
  stall_mode_e        stall_mode   = StallNone;
  bit                 gaps_on      = 1'b0;
  int unsigned        burst_left   = 0;
  int unsigned        sent         = 0;
  logic [CfgW-1:0]    cur_bytes    = '0;
  logic [CfgW-1:0]    cur_mask     = '0;
  logic [LenW-1:0]    cur_len      = LenW'(1);

  masked_byte_pattern_scanner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .region_start_i  (region_start),
    .region_base_i   (region_base),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .match_address_o (match_address),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  mbps_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .region_start_i  (region_start),
    .region_base_i   (region_base),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .match_address_i (match_address),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("[masked_byte_pattern_scanner] ERROR");
    $finish;
  end

  initial begin
    int unsigned cyc;
    int unsigned hold_cnt;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) @(posedge clk);
      end else begin
        case (stall_mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic start,
                          input logic [AddrW-1:0] base);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    data_byte    <= b;
    region_start <= start;
    region_base  <= base;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    int unsigned k;
    in_valid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < DrainLimit && pending != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] bytes_v, input logic [CfgW-1:0] mask_v,
                              input logic [LenW-1:0] len_v, input logic [1:0] align_v);
    logic [CfgW-1:0] junk;
    junk     = {$urandom, $urandom};
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgPatternBytes;
    cfg_data <= bytes_v;
    @(posedge clk);
    cfg_idx  <= CfgPatternMask;
    cfg_data <= mask_v;
    @(posedge clk);
    cfg_idx  <= CfgPatternLength;
    cfg_data <= {junk[CfgW-1:LenW], len_v};
    @(posedge clk);
    cfg_idx  <= CfgAlignMask;
    cfg_data <= {junk[CfgW-1:2], align_v};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_bytes = bytes_v;
    cur_mask  = mask_v;
    cur_len   = len_v;
  endtask

  function automatic logic [AddrW-1:0] pick_base();
    logic [AddrW-1:0] r;
    case ($urandom_range(0, 3))
      0:       r = {$urandom, $urandom};
      1:       r = '1 - AddrW'($urandom_range(0, 15));
      2:       r = {$urandom, $urandom} & ~AddrW'(3);
      default: r = AddrW'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  task automatic pick_setting();
    logic [CfgW-1:0] m;
    logic [CfgW-1:0] bts;
    logic [LenW-1:0] len_v;
    int unsigned     i;
    case ($urandom_range(0, 9))
      0:       len_v = LenW'(0);
      1:       len_v = LenW'(1);
      7:       len_v = LenW'(8);
      8:       len_v = LenW'($urandom_range(9, 15));
      default: len_v = LenW'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 3))
      0: m = '1;
      1: m = '0;
      2: m = {$urandom, $urandom};
      default: begin
        for (i = 0; i < 16; i++) m[4*i +: 4] = $urandom_range(0, 1) ? 4'hF : 4'h0;
      end
    endcase
    bts = {$urandom, $urandom};
    if ($urandom_range(0, 5) != 0) bts = bts & m;
    program_regs(bts, m, len_v, 2'($urandom_range(0, 3)));
  endtask

  task automatic run_phase(input int unsigned n);
    logic [7:0]  plan [$];
    logic [7:0]  pb;
    logic [7:0]  pm;
    int unsigned eff;
    int unsigned k;
    int unsigned i;
    eff = (cur_len > LenW'(MaxPattern)) ? MaxPattern : cur_len;
    for (k = 0; k < n; k++) begin
      if (plan.size() == 0) begin
        if (eff != 0 && $urandom_range(0, 9) < 6) begin
          for (i = 0; i < eff; i++) begin
            pb = cur_bytes[8*i +: 8];
            pm = cur_mask[8*i +: 8];
            plan.push_back((pb & pm) | (8'($urandom) & ~pm));
          end
          if ($urandom_range(0, 4) == 0) plan[$urandom_range(0, eff - 1)] = 8'($urandom);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            i = $urandom_range(0, 7);
            plan.push_back($urandom_range(0, 1) ? 8'($urandom) : cur_bytes[8*i +: 8]);
          end
        end
      end
      put_byte(plan.pop_front(), $urandom_range(0, 24) == 0, pick_base());
      sent++;
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gaps_on    = 1'b1;
    stall_mode = StallLight;
    put_byte(8'h00, 1'b0, '1);
    put_byte(8'hFF, 1'b0, '0);
    put_byte(8'hA5, 1'b0, {$urandom, $urandom});
    drain();
    program_regs(64'h01, 64'hF0, 4'd1, 2'd0);
    put_byte(8'h01, 1'b0, '0);
    put_byte(8'hF1, 1'b0, '0);
    drain();
    program_regs('0, '0, 4'd0, 2'd0);
    put_byte(8'h00, 1'b0, '0);
    put_byte(8'h3C, 1'b0, '0);
    drain();
    program_regs(64'hEFCD_AB89_6745_2301, '1, 4'hF, 2'd0);
    for (i = 0; i < 8; i++) put_byte(cur_bytes[8*i +: 8], i == 0, 64'hFFFF_FFFF_FFFF_FFFD);
    drain();
    program_regs('0, '0, 4'd2, 2'd1);
    for (i = 0; i < 4; i++) put_byte(8'($urandom), i == 0, '1);
    drain();
    program_regs('0, '0, 4'd3, 2'd3);
    for (i = 0; i < 4; i++) put_byte(8'($urandom), 1'b0, '0);

    for (k = 0; sent < RandomItems; k++) begin
      drain();
      if (k == 3) begin
        program_regs('0, '0, 4'd1, 2'd0);
        gaps_on    = 1'b0;
        stall_mode = StallNone;
        hold_req   <= 1'b1;
        run_phase(40);
      end else begin
        pick_setting();
        gaps_on    = ($urandom_range(0, 3) != 0);
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        run_phase($urandom_range(30, 60));
      end
    end
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("[masked_byte_pattern_scanner] OK");
    end else begin
      $display("[masked_byte_pattern_scanner] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scanner.sv
sim/mbps_checker.sv
sim/tb.sv
